@@ hdl/krbf_pkg.sv @@
// ----------------------------------------------------------------------------
// Key range bucketing flush: shared package
// Field widths, register indexes, result codes, transaction structs and the
// controller state type of the bucketing node.
// ----------------------------------------------------------------------------
package krbf_pkg;

  localparam int MAX_CHILDREN_DEF  = 8;
  localparam int BATCH_ENTRIES_DEF = 4;

  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int CHILD_W       = 3;
  localparam int CHILD_COUNT_W = 4;
  localparam int ENTRY_W       = KEY_W + VALUE_W;
  // The key range holds up to 2^32 keys, one bit more than a key.
  localparam int TOTAL_W       = KEY_W + 1;
  localparam int DIV_CNT_W     = $clog2(TOTAL_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHILD_COUNT = 2'd2;

  localparam logic [CHILD_COUNT_W-1:0] CHILD_COUNT_RST = 4'd8;

  localparam logic MODE_ROUTE = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam logic STATUS_FLUSH     = 1'b0;
  localparam logic STATUS_RANGE_ERR = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } upd_item_t;

  typedef struct packed {
    logic               status;
    logic [CHILD_W-1:0] child;
    logic [KEY_W-1:0]   out_key;
    logic [VALUE_W-1:0] out_value;
    logic               last;
  } res_item_t;

  typedef enum logic [3:0] {
    S_PREP,
    S_DIV,
    S_BND,
    S_IDLE,
    S_ERR,
    S_ROUTE,
    S_WR,
    S_SCAN,
    S_RD,
    S_OUT
  } state_t;

endpackage

@@ hdl/key_range_bucketing_flush.sv @@
// ----------------------------------------------------------------------------
// Key range bucketing flush
// Routes key/value updates into per-child staging buffers, flushes full
// or drained buffers as runs of result entries and reports out-of-range keys.
// ----------------------------------------------------------------------------
// Usage:
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle. After reset and after every configuration write the block
// rebuilds its child boundaries: a prep state, a 33-step bit-serial
// division of the range size by the child count, then one step for each
// of the MAX_CHILDREN-1 boundaries. upd_ready stays low during this time.
// Each update transaction on the upd channel is handled alone. A routed
// update passes through accept, child select and staging write. A key
// outside the range gives one error result from the error state. A full
// buffer and a drain emit their entries through the single-port staging
// memory, each entry read and then loaded into the result register; a drain
// also visits a scan state for every child, empty or not. Results leave
// through a registered res channel; when the receiver stalls, the block holds
// the pending result and waits, and the next update is taken once all
// results of the previous one are loaded. Reset empties all staging buffers.
// ----------------------------------------------------------------------------
module key_range_bucketing_flush #(
  parameter int MAX_CHILDREN  = krbf_pkg::MAX_CHILDREN_DEF,
  parameter int BATCH_ENTRIES = krbf_pkg::BATCH_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [krbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [krbf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          upd_valid,
  output logic                          upd_ready,
  input  krbf_pkg::upd_item_t           upd_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output krbf_pkg::res_item_t           res_data
);
  import krbf_pkg::*;

  localparam int NW    = $clog2(MAX_CHILDREN + 1);
  localparam int CHW   = $clog2(MAX_CHILDREN);
  localparam int CW    = $clog2(BATCH_ENTRIES + 1);
  localparam int DEPTH = MAX_CHILDREN * BATCH_ENTRIES;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [KEY_W-1:0]         range_low;
  logic [KEY_W-1:0]         range_high;
  logic [CHILD_COUNT_W-1:0] child_count;

  // Boundary setup
  logic [NW-1:0]        n_eff;
  logic [NW-1:0]        n_sat;
  logic [TOTAL_W-1:0]   total;
  logic [TOTAL_W-1:0]   div_quo;
  logic [NW-1:0]        div_rem;
  logic [NW-1:0]        div_rem_next;
  logic [NW:0]          div_trial;
  logic                 div_ge;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TOTAL_W-1:0]   acc;
  logic [TOTAL_W-1:0]   acc_next;
  logic [CHW-1:0]       bnd_c;
  logic [TOTAL_W-1:0]   bnd [MAX_CHILDREN];

  // Current transaction
  state_t             state;
  state_t             state_next;
  logic [KEY_W-1:0]   cur_key;
  logic [VALUE_W-1:0] cur_value;
  logic [KEY_W-1:0]   idx;
  logic               draining;
  logic               in_range;
  logic [CHW-1:0]     sel;
  logic [CHW-1:0]     em_c;
  logic [CW-1:0]      em_i;
  logic [CW-1:0]      fill [MAX_CHILDREN];
  logic [CW-1:0]      fill_cur;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      pos_inc;
  logic               wr_full;
  logic               entry_last;
  logic               em_c_last;

  // Staging memory and result register
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic               mem_re;
  logic               res_free;
  logic               res_load;
  res_item_t          res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= '0;
      range_high  <= '1;
      child_count <= CHILD_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANGE_LOW:   range_low   <= cfg_data[KEY_W-1:0];
        REG_RANGE_HIGH:  range_high  <= cfg_data[KEY_W-1:0];
        REG_CHILD_COUNT: child_count <= cfg_data[CHILD_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Range size and child count for the boundary setup
  always_comb begin
    total = {1'b0, range_high} - {1'b0, range_low} + TOTAL_W'(1);
    if (child_count == '0) begin
      n_sat = NW'(1);
    end else if (child_count > CHILD_COUNT_W'(MAX_CHILDREN)) begin
      n_sat = NW'(MAX_CHILDREN);
    end else begin
      n_sat = NW'(child_count);
    end
  end

  // One restoring division step; the remainder stays below the child count.
  always_comb begin
    div_trial    = {div_rem, div_quo[TOTAL_W-1]};
    div_ge       = div_trial >= {1'b0, n_eff};
    div_rem_next = div_ge ? NW'(div_trial - {1'b0, n_eff}) : NW'(div_trial);
  end

  // Child c starts at c*q + min(c, r); each step adds q, plus one while c <= r.
  assign acc_next = acc + div_quo + TOTAL_W'(NW'(bnd_c) <= div_rem);

  always_ff @(posedge clk) begin
    unique case (state)
      S_PREP: begin
        div_quo <= total;
        div_rem <= '0;
        div_cnt <= '0;
        n_eff   <= n_sat;
      end
      S_DIV: begin
        div_quo <= {div_quo[TOTAL_W-2:0], div_ge};
        div_rem <= div_rem_next;
        div_cnt <= div_cnt + DIV_CNT_W'(1);
        acc     <= '0;
        bnd_c   <= CHW'(1);
      end
      S_BND: begin
        bnd[bnd_c] <= acc_next;
        acc        <= acc_next;
        bnd_c      <= bnd_c + CHW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    in_range = (range_low <= range_high) && (upd_data.key >= range_low) &&
               (upd_data.key <= range_high);
  end

  // The child is the number of live boundaries at or below the key offset.
  always_comb begin
    sel = '0;
    for (int c = 1; c < MAX_CHILDREN; c++) begin
      if ((NW'(c) < n_eff) && ({1'b0, idx} >= bnd[c])) begin
        sel = sel + CHW'(1);
      end
    end
  end

  always_comb begin
    fill_cur   = fill[em_c];
    pos        = (fill_cur >= CW'(BATCH_ENTRIES)) ? CW'(BATCH_ENTRIES - 1) : fill_cur;
    pos_inc    = pos + CW'(1);
    wr_full    = pos_inc == CW'(BATCH_ENTRIES);
    entry_last = (em_i + CW'(1)) == fill_cur;
    em_c_last  = em_c == CHW'(MAX_CHILDREN - 1);
    res_free   = !res_valid || res_ready;
    mem_addr   = AW'(em_c) * AW'(BATCH_ENTRIES) + AW'((state == S_WR) ? pos : em_i);
  end

  // Next state
  always_comb begin
    state_next = state;
    if (cfg_write) begin
      state_next = S_PREP;
    end else begin
      unique case (state)
        S_PREP: state_next = S_DIV;
        S_DIV: begin
          if (div_cnt == DIV_CNT_W'(TOTAL_W - 1)) state_next = S_BND;
        end
        S_BND: begin
          if (bnd_c == CHW'(MAX_CHILDREN - 1)) state_next = S_IDLE;
        end
        S_IDLE: begin
          if (upd_valid) begin
            if (upd_data.mode == MODE_DRAIN) begin
              state_next = S_SCAN;
            end else begin
              state_next = in_range ? S_ROUTE : S_ERR;
            end
          end
        end
        S_ERR: begin
          if (res_free) state_next = S_IDLE;
        end
        S_ROUTE: state_next = S_WR;
        S_WR:    state_next = wr_full ? S_RD : S_IDLE;
        S_SCAN: begin
          if (fill_cur != '0) begin
            state_next = S_RD;
          end else if (em_c_last) begin
            state_next = S_IDLE;
          end
        end
        S_RD: state_next = S_OUT;
        S_OUT: begin
          if (res_free) begin
            if (!entry_last) begin
              state_next = S_RD;
            end else if (draining && !em_c_last) begin
              state_next = S_SCAN;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
        default: state_next = S_PREP;
      endcase
    end
  end

  // Controller outputs
  always_comb begin
    upd_ready = state == S_IDLE;
    mem_we    = state == S_WR;
    mem_re    = state == S_RD;
    res_load  = res_free && ((state == S_ERR) || (state == S_OUT));
    if (state == S_ERR) begin
      res_next.status    = STATUS_RANGE_ERR;
      res_next.child     = '0;
      res_next.out_key   = cur_key;
      res_next.out_value = cur_value;
      res_next.last      = 1'b0;
    end else begin
      res_next.status    = STATUS_FLUSH;
      res_next.child     = CHILD_W'(em_c);
      res_next.out_key   = rd_data[ENTRY_W-1:VALUE_W];
      res_next.out_value = rd_data[VALUE_W-1:0];
      res_next.last      = entry_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_PREP;
      draining <= 1'b0;
      em_c     <= '0;
      em_i     <= '0;
      for (int c = 0; c < MAX_CHILDREN; c++) begin
        fill[c] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (upd_valid) begin
            draining <= upd_data.mode == MODE_DRAIN;
            em_c     <= '0;
            em_i     <= '0;
          end
        end
        S_ROUTE: em_c <= sel;
        S_WR: begin
          fill[em_c] <= pos_inc;
          em_i       <= '0;
        end
        S_SCAN: begin
          if ((fill_cur == '0) && !em_c_last) em_c <= em_c + CHW'(1);
        end
        S_OUT: begin
          if (res_free) begin
            if (entry_last) begin
              fill[em_c] <= '0;
              em_i       <= '0;
              if (draining && !em_c_last) em_c <= em_c + CHW'(1);
            end else begin
              em_i <= em_i + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Latched update; the key offset feeds the child select.
  always_ff @(posedge clk) begin
    if (upd_valid && upd_ready) begin
      cur_key   <= upd_data.key;
      cur_value <= upd_data.value;
      idx       <= upd_data.key - range_low;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {cur_key, cur_value};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= res_next;
    end
  end

`ifndef SYNTHESIS
  // A staged entry keeps its buffer non-empty until the run is flushed.
  a_fill_after_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |=> (fill[em_c] != '0))
    else $error("staging buffer empty right after a write");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_load && entry_last) |=> (fill[$past(em_c)] == '0))
    else $error("flushed child buffer not cleared");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == STATUS_RANGE_ERR) |->
      (res_data.child == '0 && !res_data.last))
    else $error("range error result carries child or last");

  // Each transaction is handled alone; upd_ready is low in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (upd_valid && upd_ready) |=> !upd_ready)
    else $error("update accepted in back-to-back cycles");
`endif

endmodule
